FILE: rtl/drtm_pkg.sv
// shared constants, types and opcodes of the descriptor ratio-test matcher
// no dependencies; used by the interfaces, the lane, the ranking stage and the top level
`default_nettype none

package drtm_pkg;

  localparam int MAX_REFS  = 256;
  localparam int CELLS     = 16;
  localparam int COMP_W    = 16;
  localparam int LANES     = 4;

  localparam int CELL_W    = 4;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROWS      = MAX_REFS / LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int REF_IDX_W = ROW_W + LANE_W;
  localparam int REF_CNT_W = REF_IDX_W + 1;
  localparam int CADDR_W   = ROW_W + CELL_W;

  // distances are kept in Q2.28 up to the 3.0 sentinel
  localparam int ACC_W     = 2 * COMP_W - 2;
  localparam int SQ_W      = 2 * COMP_W;
  localparam int SUM_W     = 2 * COMP_W + 3;
  localparam logic [ACC_W-1:0] SENTINEL = ACC_W'(3) << (2 * COMP_W - 4);

  localparam int RATIO_W   = 16;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd42598;
  localparam int PADDR_W   = 3;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef logic [3:0][COMP_W-1:0] cell_t;

  typedef struct packed {
    logic                we;
    logic                sign_we;
    logic [ROW_W-1:0]    row;
    logic [CELL_W-1:0]   cell_no;
    cell_t               data;
    logic                sign;
  } lane_load_t;

  typedef struct packed {
    logic                first;
    logic                last;
    logic [CELL_W-1:0]   cell_no;
    cell_t               comps;
  } query_ctl_t;

  typedef struct packed {
    logic                vld;
    logic                sign;
    logic [ACC_W-1:0]    distance;
  } lane_res_t;

endpackage

`default_nettype wire

FILE: rtl/drtm_ifs.sv
// handshake channels of the matcher: query/load words in, match words out
// depends on drtm_pkg for field widths
`default_nettype none

interface drtm_req_if;
  import drtm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [CELL_W-1:0] cell_req;
  logic signed [COMP_W-1:0] sum_dx;
  logic signed [COMP_W-1:0] sum_dy;
  logic signed [COMP_W-1:0] sum_abs_dx;
  logic signed [COMP_W-1:0] sum_abs_dy;
  logic              laplacian_sign;

  modport source (output valid, opcode, cell_req, sum_dx, sum_dy, sum_abs_dx,
                  sum_abs_dy, laplacian_sign, input ready);
  modport sink   (input valid, opcode, cell_req, sum_dx, sum_dy, sum_abs_dx,
                  sum_abs_dy, laplacian_sign, output ready);
endinterface

interface drtm_rsp_if;
  import drtm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 match_found;
  logic [REF_IDX_W-1:0] ref_index;
  logic [15:0]          query_index;

  modport source (output valid, match_found, ref_index, query_index, input ready);
  modport sink   (input valid, match_found, ref_index, query_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/drtm_lane.sv
// one distance lane: reference cell, sign and accumulator memories for every
// LANES-th slot, plus a three-stage squared-distance pipeline; uses drtm_pkg
`default_nettype none

module drtm_lane (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire drtm_pkg::lane_load_t  load,
  input  wire logic                  iss_vld,
  input  wire logic                  iss_zero,
  input  wire logic [drtm_pkg::ROW_W-1:0] iss_row,
  input  wire drtm_pkg::query_ctl_t  qctl,
  output drtm_pkg::lane_res_t        res
);
  import drtm_pkg::*;

  cell_t            cells [2**CADDR_W];
  logic             signs [ROWS];
  logic [ACC_W-1:0] accs  [ROWS];

  cell_t            rd_cell;
  logic             rd_sign;
  logic [ACC_W-1:0] rd_acc;
  logic             v1;
  logic             zero1;
  logic [ROW_W-1:0] row1;

  logic [3:0][SQ_W-1:0] sq;
  logic [ACC_W-1:0] acc2;
  logic             sign2;
  logic             v2;
  logic [ROW_W-1:0] row2;

  logic [SUM_W-1:0] sum;
  logic [ACC_W-1:0] acc_new;

  always_ff @(posedge clk) begin
    if (load.we) begin
      cells[{load.row, load.cell_no}] <= load.data;
    end
    if (load.sign_we) begin
      signs[load.row] <= load.sign;
    end
    rd_cell <= cells[{iss_row, qctl.cell_no}];
    rd_sign <= signs[iss_row];
    rd_acc  <= accs[iss_row];
    if (v2) begin
      accs[row2] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      res.vld <= 1'b0;
    end else begin
      v1      <= iss_vld;
      v2      <= v1;
      res.vld <= v2 && qctl.last;
    end
  end

  // stage 2: per-component squared difference
  always_ff @(posedge clk) begin
    row1  <= iss_row;
    zero1 <= iss_zero;
    row2  <= row1;
    for (int k = 0; k < 4; k++) begin
      logic signed [COMP_W:0]     d;
      logic signed [2*COMP_W+1:0] p;
      d = COMP_W'(0) + ($signed({qctl.comps[k][COMP_W-1], qctl.comps[k]})
                        - $signed({rd_cell[k][COMP_W-1], rd_cell[k]}));
      p = d * d;
      sq[k] <= p[SQ_W-1:0];
    end
    // slots not yet swept since the query began start from zero
    acc2  <= (qctl.first || zero1) ? '0 : rd_acc;
    sign2 <= rd_sign;
    res.sign     <= sign2;
    res.distance <= acc_new;
  end

  // stage 3: accumulate and clamp at the sentinel
  always_comb begin
    sum = SUM_W'(acc2) + SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
    acc_new = (sum > SUM_W'(SENTINEL)) ? SENTINEL : sum[ACC_W-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/drtm_rank.sv
// merging stage: folds the lane results of one row, in slot order, into the
// best and second-best distances and the best slot; uses drtm_pkg
`default_nettype none

module drtm_rank (
  input  wire logic                      clk,
  input  wire logic                      start,
  input  wire logic                      qsign,
  input  wire logic [drtm_pkg::ROW_W-1:0] row,
  input  wire drtm_pkg::lane_res_t       res [drtm_pkg::LANES],
  output logic [drtm_pkg::ACC_W-1:0]     d1,
  output logic [drtm_pkg::ACC_W-1:0]     d2,
  output logic [drtm_pkg::REF_IDX_W-1:0] pos,
  output logic                           found
);
  import drtm_pkg::*;

  logic [ACC_W-1:0]     d1_next;
  logic [ACC_W-1:0]     d2_next;
  logic [REF_IDX_W-1:0] pos_next;
  logic                 found_next;

  always_comb begin
    d1_next    = d1;
    d2_next    = d2;
    pos_next   = pos;
    found_next = found;
    for (int l = 0; l < LANES; l++) begin
      if (res[l].vld && res[l].sign == qsign) begin
        if (res[l].distance < d2_next) begin
          d2_next = res[l].distance;
        end
        if (d1_next > res[l].distance) begin
          pos_next   = {row, LANE_W'(l)};
          found_next = 1'b1;
          d2_next    = d1_next;
          d1_next    = res[l].distance;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d1    <= SENTINEL;
      d2    <= SENTINEL;
      pos   <= '0;
      found <= 1'b0;
    end else begin
      d1    <= d1_next;
      d2    <= d2_next;
      pos   <= pos_next;
      found <= found_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/descriptor_ratio_test_matcher.sv
// Descriptor matcher with nearest-neighbor ratio test.
// req words carry one descriptor cell: opcode clear, load reference cell or
// query cell. A load cell is written into slot ref_count (dropped when the
// store is full); the slot counts after its last cell. A query cell walks
// all stored references LANES at a time: each cycle one row of LANES slots
// enters four parallel lanes, and req.ready stays low until the scan and the
// lane pipeline have drained. The last cell then passes through the ratio
// product, and its match word is offered on rsp (none when the test fails);
// the query number advances either way. With an empty store a query cell
// skips the scan and a last one goes straight to the ratio product. Clear
// and load are taken in the idle state and keep req.ready high.
// A finished word waits in the output register; if it is still not taken
// when the next query ends, that query holds in its final step until rsp drains.
// Reset empties the store, zeroes the query number and sets ratio to 42598.
// ratio is written over APB at address 0 (psel/penable/pwrite), read back
// there; pready is tied high.
`default_nettype none

module descriptor_ratio_test_matcher (
  input  wire logic        clk,
  input  wire logic        rst,
  drtm_req_if.sink         req,
  drtm_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [drtm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import drtm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PROD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]             state;
  logic [RATIO_W-1:0]     ratio;
  logic [2*RATIO_W-1:0]   ratio_sq;
  logic [REF_CNT_W-1:0]   ref_count;
  logic [REF_CNT_W-1:0]   acc_fill;
  logic [REF_CNT_W-1:0]   zero_from;
  logic                   qsign;
  logic [15:0]            qcnt;
  query_ctl_t             qctl;
  logic [ROW_W-1:0]       scan_row;
  logic [ROW_W-1:0]       rows_last;
  logic [2:0]             pipe;
  logic [ROW_W-1:0]       row1, row2, row3;
  logic [2*RATIO_W+ACC_W-1:0] prod;

  logic                   accept;
  logic                   cell_ok;
  logic                   is_last;
  logic                   rank_start;
  logic                   issue;
  logic [REF_CNT_W-1:0]   count_m1;
  lane_load_t             load [LANES];
  lane_res_t              res  [LANES];
  logic [LANES-1:0]       lane_vld;
  logic [LANES-1:0]       lane_zero;
  logic [ACC_W-1:0]       d1, d2;
  logic [REF_IDX_W-1:0]   pos;
  logic                   found;
  logic                   pass;

  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'd0 : 32'(ratio);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign cell_ok   = {1'b0, req.cell_req} < (CELL_W + 1)'(CELLS);
  assign is_last   = req.cell_req == CELL_W'(CELLS - 1);
  assign rank_start = accept && req.opcode == OP_QUERY && cell_ok && is_last;
  assign issue     = (state == S_SCAN);
  assign count_m1  = ref_count - REF_CNT_W'(1);
  assign pass      = prod > {d1, (2*RATIO_W)'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      ratio <= pwdata[RATIO_W-1:0];
    end
    ratio_sq <= ratio * ratio;
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      load[l].we      = accept && req.opcode == OP_LOAD && cell_ok
                        && ref_count < REF_CNT_W'(MAX_REFS)
                        && ref_count[LANE_W-1:0] == LANE_W'(l);
      load[l].sign_we = load[l].we && req.cell_req == '0;
      load[l].row     = ref_count[REF_IDX_W-1:LANE_W];
      load[l].cell_no = req.cell_req;
      load[l].data    = {req.sum_abs_dy, req.sum_abs_dx, req.sum_dy, req.sum_dx};
      load[l].sign    = req.laplacian_sign;
      lane_vld[l]     = issue && {1'b0, scan_row, LANE_W'(l)} < ref_count;
      lane_zero[l]    = {1'b0, scan_row, LANE_W'(l)} >= zero_from;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    drtm_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .load     (load[l]),
      .iss_vld  (lane_vld[l]),
      .iss_zero (lane_zero[l]),
      .iss_row  (scan_row),
      .qctl     (qctl),
      .res      (res[l])
    );
  end

  drtm_rank u_rank (
    .clk   (clk),
    .start (rank_start),
    .qsign (qsign),
    .row   (row3),
    .res   (res),
    .d1    (d1),
    .d2    (d2),
    .pos   (pos),
    .found (found)
  );

  always_ff @(posedge clk) begin
    row1 <= scan_row;
    row2 <= row1;
    row3 <= row2;
    prod <= ratio_sq * d2;
    if (accept && req.opcode == OP_QUERY && cell_ok) begin
      qctl.first   <= req.cell_req == '0;
      qctl.last    <= is_last;
      qctl.cell_no <= req.cell_req;
      qctl.comps   <= {req.sum_abs_dy, req.sum_abs_dx, req.sum_dy, req.sum_dx};
      rows_last    <= count_m1[REF_IDX_W-1:LANE_W];
    end
    if (state == S_EMIT && !(rsp.valid && !rsp.ready)) begin
      rsp.match_found <= 1'b1;
      rsp.ref_index   <= pos;
      rsp.query_index <= qcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ref_count <= '0;
      acc_fill  <= '0;
      zero_from <= '0;
      qsign     <= 1'b0;
      qcnt      <= '0;
      scan_row  <= '0;
      pipe      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      pipe <= {pipe[1:0], issue};
      if (rsp.valid && rsp.ready && state != S_EMIT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              OP_CLEAR: ref_count <= '0;
              OP_LOAD: begin
                if (cell_ok && is_last && ref_count < REF_CNT_W'(MAX_REFS)) begin
                  ref_count <= ref_count + REF_CNT_W'(1);
                end
              end
              OP_QUERY: begin
                if (cell_ok) begin
                  // slots at or above zero_from hold no sum of this query yet
                  zero_from <= acc_fill;
                  if (req.cell_req == '0) begin
                    qsign    <= req.laplacian_sign;
                    acc_fill <= ref_count;
                  end else if (ref_count > acc_fill) begin
                    acc_fill <= ref_count;
                  end
                  scan_row <= '0;
                  if (ref_count != '0) begin
                    state <= S_SCAN;
                  end else if (is_last) begin
                    state <= S_PROD;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          scan_row <= scan_row + ROW_W'(1);
          if (scan_row == rows_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait until the last row has been folded into the ranking
          if (pipe == '0) begin
            state <= qctl.last ? S_PROD : S_IDLE;
          end
        end
        S_PROD: state <= S_EMIT;
        S_EMIT: begin
          if (!(rsp.valid && !rsp.ready)) begin
            rsp.valid <= found && pass;
            qcnt      <= qcnt + 16'd1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= REF_CNT_W'(MAX_REFS))
    else $error("reference count beyond capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_row <= rows_last)
    else $error("scan issued a row past the stored references");

  a_found_dist: assert property (@(posedge clk) disable iff (rst)
    found |-> d1 < SENTINEL && d1 <= d2)
    else $error("best distance inconsistent with match flag");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_PROD |-> pipe == '0)
    else $error("ratio test started before lanes drained");
`endif

endmodule

`default_nettype wire

FILE: test/descriptor_ratio_test_matcher_test.sv
// testbench for descriptor_ratio_test_matcher: streams reference loads and query
// descriptors, predicts ratio-test matches and checks every match word
// depends on drtm_pkg, drtm_ifs and the matcher rtl
`timescale 1ns / 100ps
`default_nettype none

module descriptor_ratio_test_matcher_test;
  import drtm_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [PADDR_W-1:0] RATIO_ADDR = '0;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 150;
  localparam longint unsigned SAT_DIST = 64'd3 << (2 * COMP_W - 4);

  class match_scoreboard;
    typedef struct {
      bit [REF_IDX_W-1:0] ref_index;
      bit [15:0] query_index;
    } match_t;

    cell_t ref_cells [MAX_REFS*CELLS];
    bit ref_signs [MAX_REFS];
    int unsigned ref_count;
    longint unsigned dist_acc [MAX_REFS];
    bit query_sign;
    bit [15:0] query_num;
    bit [RATIO_W-1:0] ratio;
    match_t expected_matches[$];
    int errors;

    function new();
      ref_count = 0;
      query_sign = 0;
      query_num = 0;
      ratio = RATIO_RESET;
      errors = 0;
    endfunction

    function void finish_query();
      longint unsigned best, second, d;
      bit found;
      int unsigned pos;
      logic [95:0] prod;
      match_t m;
      best = SAT_DIST;
      second = SAT_DIST;
      found = 0;
      pos = 0;
      for (int j = 0; j < ref_count; j++) begin
        if (ref_signs[j] != query_sign) continue;
        d = dist_acc[j];
        if (d < second) second = d;
        if (best > d) begin
          pos = j;
          found = 1;
          second = best;
          best = d;
        end
      end
      // (ratio^2 / 2^32) * second > best, done exactly
      prod = 96'(ratio) * 96'(ratio) * 96'(second);
      if (found && prod > (96'(best) << 32)) begin
        m.ref_index = pos[REF_IDX_W-1:0];
        m.query_index = query_num;
        expected_matches = {expected_matches, m};
      end
      query_num++;
    endfunction

    function void note_word(logic [1:0] op, logic [3:0] cell_no, cell_t comps, logic sign);
      longint diff;
      longint unsigned acc;
      case (op)
        OP_CLEAR: ref_count = 0;
        OP_LOAD: begin
          if (ref_count < MAX_REFS) begin
            ref_cells[ref_count*CELLS + cell_no] = comps;
            if (cell_no == 0) ref_signs[ref_count] = sign;
            if (cell_no == CELLS-1) ref_count++;
          end
        end
        OP_QUERY: begin
          if (cell_no == 0) begin
            query_sign = sign;
            foreach (dist_acc[j]) dist_acc[j] = 0;
          end
          for (int j = 0; j < ref_count; j++) begin
            acc = dist_acc[j];
            for (int k = 0; k < 4; k++) begin
              diff = longint'($signed(comps[k])) -
                     longint'($signed(ref_cells[j*CELLS + cell_no][k]));
              acc += longint'(diff * diff);
            end
            if (acc > SAT_DIST) acc = SAT_DIST;
            dist_acc[j] = acc;
          end
          if (cell_no == CELLS-1) finish_query();
        end
        default: ;
      endcase
    endfunction

    function void check_match(logic found, logic [REF_IDX_W-1:0] ri, logic [15:0] qi);
      match_t m;
      if (expected_matches.size() == 0) begin
        $error("unexpected match word: ref_index %0d query_index %0d", ri, qi);
        errors++;
        return;
      end
      m = expected_matches.pop_front();
      if (found !== 1'b1) begin
        $error("match_found: expected 1 actual %0b", found);
        errors++;
      end
      if (ri !== m.ref_index) begin
        $error("ref_index: expected %0d actual %0d", m.ref_index, ri);
        errors++;
      end
      if (qi !== m.query_index) begin
        $error("query_index: expected %0d actual %0d", m.query_index, qi);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  drtm_req_if req_ch();
  drtm_rsp_if rsp_ch();

  descriptor_ratio_test_matcher u_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  match_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int words_sent;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // sample both channels at the edge where the words move
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_word(req_ch.opcode, req_ch.cell_req,
                     {req_ch.sum_abs_dy, req_ch.sum_abs_dx, req_ch.sum_dy, req_ch.sum_dx},
                     req_ch.laplacian_sign);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_match(rsp_ch.match_found, rsp_ch.ref_index, rsp_ch.query_index);
      end
      idle_cycles <= ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                     ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [3:0] cell_no, cell_t comps, logic sign);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid = 0;
      @(negedge clk);
    end
    req_ch.valid = 1;
    req_ch.opcode = op;
    req_ch.cell_req = cell_no;
    req_ch.sum_dx = comps[0];
    req_ch.sum_dy = comps[1];
    req_ch.sum_abs_dx = comps[2];
    req_ch.sum_abs_dy = comps[3];
    req_ch.laplacian_sign = sign;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (op != OP_NONE) words_sent++;
  endtask

  function automatic cell_t random_cell(int spread);
    cell_t c;
    for (int k = 0; k < 4; k++)
      c[k] = (spread == 0) ? 16'($urandom) : 16'(int'($urandom_range(2*spread)) - spread);
    return c;
  endfunction

  function automatic cell_t jitter_cell(cell_t base, int n);
    cell_t c;
    for (int k = 0; k < 4; k++)
      c[k] = 16'(int'($signed(base[k])) + int'($urandom_range(2*n)) - n);
    return c;
  endfunction

  task automatic load_desc(int cells, logic sign, int spread);
    for (int c = 0; c < cells; c++) send_word(OP_LOAD, 4'(c), random_cell(spread), sign);
  endtask

  task automatic load_const(logic [15:0] v, logic sign);
    for (int c = 0; c < CELLS; c++) send_word(OP_LOAD, 4'(c), {4{v}}, sign);
  endtask

  task automatic query_const(int cells, logic [15:0] v, logic sign);
    for (int c = 0; c < cells; c++) send_word(OP_QUERY, 4'(c), {4{v}}, sign);
  endtask

  // query built from a stored reference plus a little noise
  task automatic query_near(int cells, int slot, logic sign, int n);
    for (int c = 0; c < cells; c++)
      send_word(OP_QUERY, 4'(c), jitter_cell(sb.ref_cells[slot*CELLS + c], n), sign);
  endtask

  task automatic write_ratio(logic [RATIO_W-1:0] v);
    psel = 1;
    pwrite = 1;
    paddr = RATIO_ADDR;
    pwdata = 32'(v);
    penable = 0;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    sb.ratio = v;
  endtask

  task automatic drain();
    req_ch.valid = 0;
    while (sb.expected_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic directed_words();
    send_word(OP_CLEAR, 0, '0, 0);
    load_const(16'h7fff, 1);
    load_const(16'h8000, 0);
    load_const(16'h0000, 1);
    query_const(CELLS, 16'h0000, 1);
    query_const(CELLS, 16'h8000, 0);
    query_const(7, 16'h7fff, 1);
    send_word(OP_NONE, 4'hf, {4{16'hffff}}, 1);
    query_const(CELLS, 16'h7fff, 1);
  endtask

  task automatic random_words(int n_words);
    int stop_at, pick, slot, noise;
    logic sign;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10 || sb.ref_count == 0) begin
        send_word(OP_CLEAR, 4'($urandom), random_cell(0), $urandom_range(1));
        repeat ($urandom_range(1, 10))
          load_desc(CELLS, $urandom_range(1), ($urandom_range(9) == 0) ? 0 : 1500);
      end else if (pick < 68) begin
        slot = $urandom_range(sb.ref_count - 1);
        sign = sb.ref_signs[slot] ^ ($urandom_range(9) == 0);
        case ($urandom_range(3))
          0: noise = 0;
          1: noise = 8;
          2: noise = 64;
          default: noise = 400;
        endcase
        query_near(CELLS, slot, sign, noise);
      end else if (pick < 78) begin
        sign = $urandom_range(1);
        for (int c = 0; c < CELLS; c++) send_word(OP_QUERY, 4'(c), random_cell(0), sign);
      end else if (pick < 86) begin
        // abandoned query, the next one restarts at cell 0
        slot = $urandom_range(sb.ref_count - 1);
        query_near($urandom_range(1, CELLS-1), slot, sb.ref_signs[slot], 30);
      end else if (pick < 94) begin
        load_desc($urandom_range(1, CELLS-1), $urandom_range(1), 1500);
      end else begin
        send_word(OP_NONE, 4'($urandom), random_cell(0), $urandom_range(1));
      end
    end
  endtask

  initial begin
    logic [RATIO_W-1:0] ratios [3][3];
    sb = new();
    words_sent = 0;
    idle_cycles = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 72;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 0;
    req_ch.opcode = OP_CLEAR;
    req_ch.cell_req = '0;
    req_ch.sum_dx = '0;
    req_ch.sum_dy = '0;
    req_ch.sum_abs_dx = '0;
    req_ch.sum_abs_dy = '0;
    req_ch.laplacian_sign = 0;
    rsp_ch.ready = 0;
    ratios = '{'{RATIO_RESET, 16'd0, 16'hffff},
               '{16'($urandom), 16'd52000, 16'd30000},
               '{16'hffff, 16'($urandom), RATIO_RESET}};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed_words();
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 12 : (p == 1) ? 72 : 0;
      rx_idle_pct = (p == 0) ? 72 : (p == 1) ? 12 : 0;
      for (int s = 0; s < 3; s++) begin
        drain();
        write_ratio(ratios[p][s]);
        random_words(85);
      end
    end
    drain();

    if (sb.errors == 0 && sb.expected_matches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
